/* rtl/vdn_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and codes of the vector distance, norm and dot unit
package vdn_pkg;

    localparam int ELEM_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int SUM_WIDTH  = 48;
    localparam int OUT_WIDTH  = 48;
    localparam int MODE_WIDTH = 3;

    // one sign bit more for the difference, one more again for the unsigned magnitudes
    localparam int DIFF_WIDTH = ELEM_WIDTH + 1;
    localparam int OPND_WIDTH = ELEM_WIDTH + 2;
    localparam int TERM_WIDTH = 2 * OPND_WIDTH;

    // root takes one result bit per iteration
    localparam int ROOT_STEPS = (SUM_WIDTH + 1) / 2;
    localparam int STEP_WIDTH = $clog2(ROOT_STEPS + 1);

    localparam logic [SUM_WIDTH-1:0] SUM_MAX  = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SUM_MIN  = {1'b1, {(SUM_WIDTH - 1){1'b0}}};
    localparam logic [SUM_WIDTH-1:0] ONE_INIT = SUM_WIDTH'(1) << (2 * (ROOT_STEPS - 1));

    localparam logic [MODE_WIDTH-1:0] MODE_L1_DIST = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_L2_DIST = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_L1_NORM = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_L2_NORM = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_DOT     = 3'd4;

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] x_element;
        logic signed [ELEM_WIDTH-1:0] y_element;
        logic                         last_element;
    } vdn_in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] metric_value;
        logic                        saturated;
    } vdn_out_t;

    typedef enum logic [1:0] {
        VDN_RUN,
        VDN_ROOT,
        VDN_EMIT
    } vdn_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic root_step;
        logic emit;
    } vdn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic finalize;
        logic root_mode;
        logic root_last;
        logic out_free;
    } vdn_status_t;

endpackage

/* rtl/vdn_ctrl.sv */
`timescale 1ns / 1ps
// controller state machine of the vector distance, norm and dot unit
module vdn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  vdn_pkg::vdn_status_t status,
    output vdn_pkg::vdn_cmd_t    cmd
);

    vdn_pkg::vdn_state_t state_reg;
    vdn_pkg::vdn_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdn_pkg::VDN_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vdn_pkg::VDN_RUN:
            begin
                if (status.finalize)
                begin
                    state_next = status.root_mode ? vdn_pkg::VDN_ROOT : vdn_pkg::VDN_EMIT;
                end
            end
            vdn_pkg::VDN_ROOT:
            begin
                if (status.root_last)
                begin
                    state_next = vdn_pkg::VDN_EMIT;
                end
            end
            vdn_pkg::VDN_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = vdn_pkg::VDN_RUN;
                end
            end
            default:
            begin
                state_next = vdn_pkg::VDN_RUN;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            vdn_pkg::VDN_RUN:
            begin
                // hold input while the last term of a vector is being summed
                cmd.take = !status.finalize;
            end
            vdn_pkg::VDN_ROOT:
            begin
                cmd.root_step = 1'b1;
            end
            vdn_pkg::VDN_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/vdn_datapath.sv */
`timescale 1ns / 1ps
// term, saturating accumulator, bit-serial root and output register
module vdn_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [vdn_pkg::MODE_WIDTH-1:0]      cfg_data,
    input  logic                                in_valid,
    input  vdn_pkg::vdn_in_t                    in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output vdn_pkg::vdn_out_t                   out_item,
    input  vdn_pkg::vdn_cmd_t                   cmd,
    output vdn_pkg::vdn_status_t                status
);

    logic [vdn_pkg::MODE_WIDTH-1:0]          mode_reg;

    logic                                    term_valid_reg;
    logic signed [vdn_pkg::TERM_WIDTH-1:0]   term_reg;
    logic signed [vdn_pkg::TERM_WIDTH-1:0]   term_next;
    logic                                    term_last_reg;
    logic                                    term_root_reg;

    logic signed [vdn_pkg::SUM_WIDTH-1:0]    sum_reg;
    logic                                    clip_reg;

    logic [vdn_pkg::SUM_WIDTH-1:0]           rem_reg;
    logic [vdn_pkg::SUM_WIDTH-1:0]           part_reg;
    logic [vdn_pkg::SUM_WIDTH-1:0]           one_reg;
    logic [vdn_pkg::STEP_WIDTH-1:0]          step_reg;
    logic                                    root_sel_reg;
    logic                                    hold_clip_reg;

    logic                                    out_valid_reg;
    logic signed [vdn_pkg::OUT_WIDTH-1:0]    out_value_reg;
    logic                                    out_sat_reg;

    logic                                    in_fire;
    logic                                    out_fire;
    logic                                    finalize;

    logic signed [vdn_pkg::DIFF_WIDTH-1:0]   diff;
    logic signed [vdn_pkg::DIFF_WIDTH-1:0]   x_ext;
    logic [vdn_pkg::DIFF_WIDTH-1:0]          abs_diff;
    logic [vdn_pkg::DIFF_WIDTH-1:0]          abs_x;
    logic signed [vdn_pkg::OPND_WIDTH-1:0]   op_a;
    logic signed [vdn_pkg::OPND_WIDTH-1:0]   op_b;
    logic signed [vdn_pkg::TERM_WIDTH-1:0]   product;

    logic signed [vdn_pkg::SUM_WIDTH:0]      sum_ext;
    logic                                    ovf;
    logic [vdn_pkg::SUM_WIDTH-1:0]           sat_sum;
    logic [vdn_pkg::SUM_WIDTH:0]             trial;

    assign in_fire  = in_valid && cmd.take;
    assign out_fire = out_valid_reg && !out_stall;
    assign finalize = term_valid_reg && term_last_reg;

    // term of the element pair, one multiplier shared by the squared modes and the dot
    always_comb
    begin
        x_ext    = vdn_pkg::DIFF_WIDTH'(in_item.x_element);
        diff     = x_ext - vdn_pkg::DIFF_WIDTH'(in_item.y_element);
        abs_diff = diff[vdn_pkg::DIFF_WIDTH-1] ? vdn_pkg::DIFF_WIDTH'(-diff)
                                               : vdn_pkg::DIFF_WIDTH'(diff);
        abs_x    = x_ext[vdn_pkg::DIFF_WIDTH-1] ? vdn_pkg::DIFF_WIDTH'(-x_ext)
                                                : vdn_pkg::DIFF_WIDTH'(x_ext);
        op_a     = vdn_pkg::OPND_WIDTH'(in_item.x_element);
        op_b     = vdn_pkg::OPND_WIDTH'(in_item.y_element);
        if (mode_reg == vdn_pkg::MODE_L2_DIST)
        begin
            op_a = signed'({1'b0, abs_diff});
            op_b = signed'({1'b0, abs_diff});
        end
        else if (mode_reg == vdn_pkg::MODE_L2_NORM)
        begin
            op_a = signed'({1'b0, abs_x});
            op_b = signed'({1'b0, abs_x});
        end
        product = vdn_pkg::TERM_WIDTH'(op_a) * vdn_pkg::TERM_WIDTH'(op_b);

        unique case (mode_reg)
            vdn_pkg::MODE_L1_DIST: term_next = signed'(vdn_pkg::TERM_WIDTH'(abs_diff));
            vdn_pkg::MODE_L1_NORM: term_next = signed'(vdn_pkg::TERM_WIDTH'(abs_x));
            vdn_pkg::MODE_L2_DIST,
            vdn_pkg::MODE_L2_NORM,
            vdn_pkg::MODE_DOT:     term_next = product;
            default:               term_next = '0;
        endcase
    end

    // saturating add, overflow when the two top bits of the wide sum differ
    always_comb
    begin
        sum_ext = (vdn_pkg::SUM_WIDTH + 1)'(sum_reg) + (vdn_pkg::SUM_WIDTH + 1)'(term_reg);
        ovf     = sum_ext[vdn_pkg::SUM_WIDTH] != sum_ext[vdn_pkg::SUM_WIDTH-1];
        if (ovf)
        begin
            sat_sum = sum_ext[vdn_pkg::SUM_WIDTH] ? vdn_pkg::SUM_MIN : vdn_pkg::SUM_MAX;
        end
        else
        begin
            sat_sum = sum_ext[vdn_pkg::SUM_WIDTH-1:0];
        end
        trial = {1'b0, part_reg} + {1'b0, one_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= vdn_pkg::MODE_L1_DIST;
            term_valid_reg <= 1'b0;
            sum_reg        <= '0;
            clip_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
            term_valid_reg <= in_fire;
            if (term_valid_reg)
            begin
                if (term_last_reg)
                begin
                    sum_reg  <= '0;
                    clip_reg <= 1'b0;
                end
                else
                begin
                    sum_reg  <= signed'(sat_sum);
                    clip_reg <= clip_reg | ovf;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            term_reg      <= term_next;
            term_last_reg <= in_item.last_element;
            term_root_reg <= (mode_reg == vdn_pkg::MODE_L2_DIST)
                          || (mode_reg == vdn_pkg::MODE_L2_NORM);
        end

        if (finalize)
        begin
            // root of a negative sum is taken of zero
            rem_reg       <= (term_root_reg && sat_sum[vdn_pkg::SUM_WIDTH-1]) ? '0 : sat_sum;
            part_reg      <= '0;
            one_reg       <= vdn_pkg::ONE_INIT;
            step_reg      <= vdn_pkg::STEP_WIDTH'(vdn_pkg::ROOT_STEPS);
            root_sel_reg  <= term_root_reg;
            hold_clip_reg <= clip_reg | ovf;
        end
        else if (cmd.root_step)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_reg  <= rem_reg - trial[vdn_pkg::SUM_WIDTH-1:0];
                part_reg <= (part_reg >> 1) + one_reg;
            end
            else
            begin
                part_reg <= part_reg >> 1;
            end
            one_reg  <= one_reg >> 2;
            step_reg <= step_reg - vdn_pkg::STEP_WIDTH'(1);
        end

        if (cmd.emit)
        begin
            out_value_reg <= root_sel_reg ? vdn_pkg::OUT_WIDTH'(signed'(part_reg))
                                          : vdn_pkg::OUT_WIDTH'(signed'(rem_reg));
            out_sat_reg   <= hold_clip_reg;
        end
    end

    assign status.finalize  = finalize;
    assign status.root_mode = term_root_reg;
    assign status.root_last = step_reg == vdn_pkg::STEP_WIDTH'(1);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid             = out_valid_reg;
    assign out_item.metric_value = out_value_reg;
    assign out_item.saturated    = out_sat_reg;

endmodule

/* rtl/vector_distance_norm_dot_unit.sv */
`timescale 1ns / 1ps
// top level of the vector distance, norm and dot unit
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_stall   | in_item: x_element, y_element, last_element
//  output   | out_valid / out_stall | out_item: metric_value, saturated
//  config   | cfg_write             | cfg_data: metric_mode
//
// within a vector one element pair transfers per cycle: a term register (one
//   multiplier) feeds a saturating accumulator one stage later
// the last pair closes the vector: input holds while the vector closes and the result loads,
//   and in l2 modes also while the bit-serial root yields one bit per cycle
// the result waits in the output register; while it is stalled the next vector's
//   result cannot load, and input holds only once that next vector closes too
// reset clears the sum, the clip flag, the output valid and sets mode to l1 distance
module vector_distance_norm_dot_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [vdn_pkg::MODE_WIDTH-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  vdn_pkg::vdn_in_t               in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output vdn_pkg::vdn_out_t              out_item
);

    vdn_pkg::vdn_cmd_t    cmd;
    vdn_pkg::vdn_status_t status;

    // controller sequences the vector close, root iterations and result load
    vdn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // datapath holds mode, term stage, accumulator, root unit and output register
    vdn_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cmd       (cmd),
        .status    (status)
    );

    // input transfers only in the accumulate phase
    assign in_stall = !cmd.take;

    // no element pair transfers while the root unit iterates
    a_no_take_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_step |-> in_stall)
        else $error("input transfer during root iterations");

    // a result load always shows up as a valid output next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("result load lost");

    // output valid rises only after a result load
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.emit))
        else $error("output valid without result load");

    // a vector closes only in the accumulate phase, never during root iterations or a result load
    a_close_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        status.finalize |-> !cmd.root_step && !cmd.emit)
        else $error("vector closed outside accumulate phase");

endmodule
